>>> hdl/pidd_pkg.sv
// Shared types and constants for the dual-channel PID drive controller.
`timescale 1ns / 1ps
package pidd_pkg;

  // Fixed field widths and limits
  localparam int GAIN_BITS     = 28;
  localparam int SUM_BITS      = 32;
  localparam int DRIVE_BITS    = 15;
  localparam int DRIVE_LIMIT   = 12288;
  localparam int OUT_FRAC_BITS = 10;
  localparam int ADDR_BITS     = 5;
  localparam int DATA_BITS     = 32;

  // Gain reset values, raw Q4.24 bits
  localparam logic [GAIN_BITS-1:0] LEFT_KP_RST  = GAIN_BITS'(315412);
  localparam logic [GAIN_BITS-1:0] LEFT_KI_RST  = GAIN_BITS'(185);
  localparam logic [GAIN_BITS-1:0] LEFT_KD_RST  = GAIN_BITS'(671089);
  localparam logic [GAIN_BITS-1:0] RIGHT_KP_RST = GAIN_BITS'(335544);
  localparam logic [GAIN_BITS-1:0] RIGHT_KI_RST = GAIN_BITS'(185);
  localparam logic [GAIN_BITS-1:0] RIGHT_KD_RST = GAIN_BITS'(671089);

  // Register index, word address bits [4:2]
  typedef enum logic [2:0] {
    REG_LEFT_TARGET  = 3'd0,
    REG_RIGHT_TARGET = 3'd1,
    REG_LEFT_KP      = 3'd2,
    REG_LEFT_KI      = 3'd3,
    REG_LEFT_KD      = 3'd4,
    REG_RIGHT_KP     = 3'd5,
    REG_RIGHT_KI     = 3'd6,
    REG_RIGHT_KD     = 3'd7
  } pidd_reg_e;

  // Pipeline load strobes shared by both lanes
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } pidd_load_t;

endpackage

>>> hdl/pidd_regs.sv
// APB register file: targets and gains for both wheels.
`timescale 1ns / 1ps
module pidd_regs #(
  parameter int POSITION_BITS = 21
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [pidd_pkg::ADDR_BITS-1:0]          paddr,
  input  logic [pidd_pkg::DATA_BITS-1:0]          pwdata,
  output logic [pidd_pkg::DATA_BITS-1:0]          prdata,
  output logic                                    pready,
  output logic signed [POSITION_BITS-1:0]         left_target_o,
  output logic signed [POSITION_BITS-1:0]         right_target_o,
  output logic [pidd_pkg::GAIN_BITS-1:0]          left_kp_o,
  output logic [pidd_pkg::GAIN_BITS-1:0]          left_ki_o,
  output logic [pidd_pkg::GAIN_BITS-1:0]          left_kd_o,
  output logic [pidd_pkg::GAIN_BITS-1:0]          right_kp_o,
  output logic [pidd_pkg::GAIN_BITS-1:0]          right_ki_o,
  output logic [pidd_pkg::GAIN_BITS-1:0]          right_kd_o
);
  import pidd_pkg::*;

  logic signed [POSITION_BITS-1:0] left_target_q, right_target_q;
  logic [GAIN_BITS-1:0] left_kp_q, left_ki_q, left_kd_q;
  logic [GAIN_BITS-1:0] right_kp_q, right_ki_q, right_kd_q;
  logic                 wr_en;
  pidd_reg_e            idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = pidd_reg_e'(paddr[ADDR_BITS-1:2]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_target_q  <= '0;
      right_target_q <= '0;
      left_kp_q      <= LEFT_KP_RST;
      left_ki_q      <= LEFT_KI_RST;
      left_kd_q      <= LEFT_KD_RST;
      right_kp_q     <= RIGHT_KP_RST;
      right_ki_q     <= RIGHT_KI_RST;
      right_kd_q     <= RIGHT_KD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_LEFT_TARGET:  left_target_q  <= pwdata[POSITION_BITS-1:0];
        REG_RIGHT_TARGET: right_target_q <= pwdata[POSITION_BITS-1:0];
        REG_LEFT_KP:      left_kp_q      <= pwdata[GAIN_BITS-1:0];
        REG_LEFT_KI:      left_ki_q      <= pwdata[GAIN_BITS-1:0];
        REG_LEFT_KD:      left_kd_q      <= pwdata[GAIN_BITS-1:0];
        REG_RIGHT_KP:     right_kp_q     <= pwdata[GAIN_BITS-1:0];
        REG_RIGHT_KI:     right_ki_q     <= pwdata[GAIN_BITS-1:0];
        REG_RIGHT_KD:     right_kd_q     <= pwdata[GAIN_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Read mux; targets read back sign-extended
  always_comb begin
    case (idx)
      REG_LEFT_TARGET:  prdata = DATA_BITS'(left_target_q);
      REG_RIGHT_TARGET: prdata = DATA_BITS'(right_target_q);
      REG_LEFT_KP:      prdata = DATA_BITS'(left_kp_q);
      REG_LEFT_KI:      prdata = DATA_BITS'(left_ki_q);
      REG_LEFT_KD:      prdata = DATA_BITS'(left_kd_q);
      REG_RIGHT_KP:     prdata = DATA_BITS'(right_kp_q);
      REG_RIGHT_KI:     prdata = DATA_BITS'(right_ki_q);
      REG_RIGHT_KD:     prdata = DATA_BITS'(right_kd_q);
      default:          prdata = '0;
    endcase
  end

  assign left_target_o  = left_target_q;
  assign right_target_o = right_target_q;
  assign left_kp_o      = left_kp_q;
  assign left_ki_o      = left_ki_q;
  assign left_kd_o      = left_kd_q;
  assign right_kp_o     = right_kp_q;
  assign right_ki_o     = right_ki_q;
  assign right_kd_o     = right_kd_q;

endmodule

>>> hdl/pidd_lane.sv
// One PID lane: error terms, three gain products, sum, rounding and clamp.
`timescale 1ns / 1ps
module pidd_lane #(
  parameter int POSITION_BITS      = 21,
  parameter int GAIN_FRACTION_BITS = 24
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pidd_pkg::pidd_load_t                 load_i,
  input  logic signed [POSITION_BITS-1:0]      target_i,
  input  logic [pidd_pkg::GAIN_BITS-1:0]       kp_i,
  input  logic [pidd_pkg::GAIN_BITS-1:0]       ki_i,
  input  logic [pidd_pkg::GAIN_BITS-1:0]       kd_i,
  input  logic signed [POSITION_BITS-1:0]      position_i,
  output logic signed [pidd_pkg::DRIVE_BITS-1:0] drive_o,
  output logic                                 clipped_o
);
  import pidd_pkg::*;

  localparam int EW  = POSITION_BITS + 1;              // error
  localparam int DW  = EW + 1;                         // derivative
  localparam int SXW = ((EW > SUM_BITS) ? EW : SUM_BITS) + 1;
  localparam int PPW = GAIN_BITS + 1 + EW;
  localparam int PDW = GAIN_BITS + 1 + DW;
  localparam int PIW = GAIN_BITS + 1 + SUM_BITS;
  localparam int AW  = GAIN_BITS + 1 + ((DW > SUM_BITS) ? DW : SUM_BITS) + 2;
  localparam int SH  = GAIN_FRACTION_BITS - OUT_FRAC_BITS;

  localparam logic signed [SXW-1:0] SUM_MAX = SXW'({1'b0, {(SUM_BITS-1){1'b1}}});
  localparam logic signed [SXW-1:0] SUM_MIN = -SUM_MAX - SXW'(1);
  localparam logic signed [AW-1:0]  LIM_HI  = AW'(DRIVE_LIMIT);
  localparam logic signed [AW-1:0]  LIM_LO  = -LIM_HI;

  // Lane state
  logic signed [EW-1:0]       last_err_q;
  logic signed [SUM_BITS-1:0] sum_q;

  logic signed [EW-1:0]       err_d;
  logic signed [DW-1:0]       der_d;
  logic signed [SXW-1:0]      sum_ext;
  logic signed [SUM_BITS-1:0] sum_d;

  logic signed [EW-1:0]       err1_q;
  logic signed [DW-1:0]       der1_q;
  logic signed [SUM_BITS-1:0] sum1_q;

  logic signed [PPW-1:0]      pp_q;
  logic signed [PDW-1:0]      pd_q;
  logic signed [PIW-1:0]      pi_q;

  logic signed [AW-1:0]       rnd;
  logic signed [AW-1:0]       acc_d, acc_q;
  logic signed [AW-1:0]       scaled;

  // Stage 1: error, derivative, saturating sum
  always_comb begin
    err_d   = EW'(target_i) - EW'(position_i);
    der_d   = DW'(err_d) - DW'(last_err_q);
    sum_ext = SXW'(sum_q) + SXW'(err_d);
    if (sum_ext > SUM_MAX) begin
      sum_d = SUM_BITS'(SUM_MAX);
    end else if (sum_ext < SUM_MIN) begin
      sum_d = SUM_BITS'(SUM_MIN);
    end else begin
      sum_d = SUM_BITS'(sum_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_err_q <= '0;
      sum_q      <= '0;
    end else if (load_i.s1) begin
      last_err_q <= err_d;
      sum_q      <= sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i.s1) begin
      err1_q <= err_d;
      der1_q <= der_d;
      sum1_q <= sum_d;
    end
  end

  // Stage 2: gain products
  always_ff @(posedge clk_i) begin
    if (load_i.s2) begin
      pp_q <= $signed({1'b0, kp_i}) * err1_q;
      pd_q <= $signed({1'b0, kd_i}) * der1_q;
      pi_q <= $signed({1'b0, ki_i}) * sum1_q;
    end
  end

  // Stage 3: sum with rounding offset
  assign acc_d = AW'(pp_q) + AW'(pd_q) + AW'(pi_q) + rnd;

  always_ff @(posedge clk_i) begin
    if (load_i.s3) begin
      acc_q <= acc_d;
    end
  end

  // Scale to 1/1024 volt
  generate
    if (SH > 0) begin : g_shr
      assign rnd    = AW'(1) <<< (SH - 1);
      assign scaled = acc_q >>> SH;
    end else begin : g_shl
      logic signed [AW-1:0] pre;
      assign rnd = '0;
      // pre-clamp keeps the left shift inside the word
      always_comb begin
        if (acc_q > LIM_HI + AW'(1)) begin
          pre = LIM_HI + AW'(1);
        end else if (acc_q < LIM_LO - AW'(1)) begin
          pre = LIM_LO - AW'(1);
        end else begin
          pre = acc_q;
        end
      end
      assign scaled = pre <<< (-SH);
    end
  endgenerate

  // Drive saturation, result goes to the merge register
  always_comb begin
    if (scaled > LIM_HI) begin
      drive_o   = DRIVE_BITS'(LIM_HI);
      clipped_o = 1'b1;
    end else if (scaled < LIM_LO) begin
      drive_o   = DRIVE_BITS'(LIM_LO);
      clipped_o = 1'b1;
    end else begin
      drive_o   = DRIVE_BITS'(scaled);
      clipped_o = 1'b0;
    end
  end

endmodule

>>> hdl/dual_channel_pid_drive_top.sv
// Dual-channel PID drive controller top level: register file, two lanes, merge stage.
//
// Usage: each input item carries the left and right wheel positions (signed degrees).
// It is accepted at a clock edge with in_valid_i high and in_stall_o low. Each
// item yields one result item: the left and right drive values in 1/1024 volt,
// clamped to +/-12288, and a clipped flag per side. A result is taken at an edge
// with out_valid_o high and out_stall_i low.
// An accepted item moves through the stage 1, stage 2 and stage 3 registers into the
// output register, which raises out_valid_o; throughput is one item per cycle while
// the receiver does not stall, since all stages (error, products, sum, round and
// clamp into the shared output register) advance together.
// When the receiver stalls, the result holds in the output register and the
// pipeline keeps accepting until every stage is full; in_stall_o then rises.
// Reset (rst_ni low, asynchronous) empties the pipeline, clears both lanes'
// previous error and error sum, zeros the targets and loads the default gains.
// Targets and gains must be written over the APB port only while the block is idle
// (not enforced); pready is always high and reads return the register values.
`timescale 1ns / 1ps
module dual_channel_pid_drive_top #(
  parameter int POSITION_BITS      = 21,
  parameter int GAIN_FRACTION_BITS = 24
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [pidd_pkg::ADDR_BITS-1:0]         paddr,
  input  logic [pidd_pkg::DATA_BITS-1:0]         pwdata,
  output logic [pidd_pkg::DATA_BITS-1:0]         prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [POSITION_BITS-1:0]        left_position_i,
  input  logic signed [POSITION_BITS-1:0]        right_position_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [pidd_pkg::DRIVE_BITS-1:0] left_drive_o,
  output logic signed [pidd_pkg::DRIVE_BITS-1:0] right_drive_o,
  output logic                                   left_clipped_o,
  output logic                                   right_clipped_o
);
  import pidd_pkg::*;

  logic signed [POSITION_BITS-1:0] left_target, right_target;
  logic [GAIN_BITS-1:0] left_kp, left_ki, left_kd, right_kp, right_ki, right_kd;

  logic v1_q, v2_q, v3_q, vo_q;
  logic v1_d, v2_d, v3_d, vo_d;
  logic ld4;
  pidd_load_t load;

  logic signed [DRIVE_BITS-1:0] left_drive, right_drive;
  logic                         left_clipped, right_clipped;
  logic signed [DRIVE_BITS-1:0] left_drive_q, right_drive_q;
  logic                         left_clipped_q, right_clipped_q;

  pidd_regs #(
    .POSITION_BITS(POSITION_BITS)
  ) u_regs (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .left_target_o  (left_target),
    .right_target_o (right_target),
    .left_kp_o      (left_kp),
    .left_ki_o      (left_ki),
    .left_kd_o      (left_kd),
    .right_kp_o     (right_kp),
    .right_ki_o     (right_ki),
    .right_kd_o     (right_kd)
  );

  // Stage advance: a stage loads when its upstream holds an item and it can move on
  always_comb begin
    ld4     = v3_q && (!vo_q || !out_stall_i);
    load.s3 = v2_q && (!v3_q || ld4);
    load.s2 = v1_q && (!v2_q || load.s3);
    in_stall_o = v1_q && !load.s2;
    load.s1 = in_valid_i && !in_stall_o;
    v1_d = load.s1 || (v1_q && !load.s2);
    v2_d = load.s2 || (v2_q && !load.s3);
    v3_d = load.s3 || (v3_q && !ld4);
    vo_d = ld4 || (vo_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
      vo_q <= vo_d;
    end
  end

  pidd_lane #(
    .POSITION_BITS      (POSITION_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_lane_left (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .target_i   (left_target),
    .kp_i       (left_kp),
    .ki_i       (left_ki),
    .kd_i       (left_kd),
    .position_i (left_position_i),
    .drive_o    (left_drive),
    .clipped_o  (left_clipped)
  );

  pidd_lane #(
    .POSITION_BITS      (POSITION_BITS),
    .GAIN_FRACTION_BITS (GAIN_FRACTION_BITS)
  ) u_lane_right (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (load),
    .target_i   (right_target),
    .kp_i       (right_kp),
    .ki_i       (right_ki),
    .kd_i       (right_kd),
    .position_i (right_position_i),
    .drive_o    (right_drive),
    .clipped_o  (right_clipped)
  );

  // Merge stage: both lanes' results into one output item
  always_ff @(posedge clk_i) begin
    if (ld4) begin
      left_drive_q    <= left_drive;
      right_drive_q   <= right_drive;
      left_clipped_q  <= left_clipped;
      right_clipped_q <= right_clipped;
    end
  end

  assign out_valid_o     = vo_q;
  assign left_drive_o    = left_drive_q;
  assign right_drive_o   = right_drive_q;
  assign left_clipped_o  = left_clipped_q;
  assign right_clipped_o = right_clipped_q;

endmodule

>>> hdl/pidd_checker.sv
// Port-level checks for the dual-channel PID drive controller, bound to the top.
`timescale 1ns / 1ps
module pidd_checker (
  input logic                                   clk_i,
  input logic                                   rst_ni,
  input logic                                   in_valid_i,
  input logic                                   in_stall_o,
  input logic                                   out_valid_o,
  input logic                                   out_stall_i,
  input logic signed [pidd_pkg::DRIVE_BITS-1:0] left_drive_o,
  input logic signed [pidd_pkg::DRIVE_BITS-1:0] right_drive_o,
  input logic                                   left_clipped_o,
  input logic                                   right_clipped_o
);
  import pidd_pkg::*;

  localparam logic signed [DRIVE_BITS-1:0] LIM_HI = DRIVE_BITS'(DRIVE_LIMIT);
  localparam logic signed [DRIVE_BITS-1:0] LIM_LO = -LIM_HI;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Input backpressure only comes from a stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output stall");

  // A clipped side sits on a rail
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |->
      (!left_clipped_o || left_drive_o == LIM_HI || left_drive_o == LIM_LO) &&
      (!right_clipped_o || right_drive_o == LIM_HI || right_drive_o == LIM_LO))
    else $error("clipped flag without saturated drive");

  // With a free receiver an accepted item passes all stage registers and shows up
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i
      |=> out_valid_o)
    else $error("result late");

endmodule

bind dual_channel_pid_drive_top pidd_checker u_pidd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .left_drive_o    (left_drive_o),
  .right_drive_o   (right_drive_o),
  .left_clipped_o  (left_clipped_o),
  .right_clipped_o (right_clipped_o)
);
